[rtl/csg_pkg.sv]
package csg_pkg;

   // Largest rank count that a plan may span.
   localparam int MAX_RANKS = 64;

   // Width of a rank count, wide enough to hold MAX_RANKS itself.
   localparam int RANK_CNT_BITS = 7;

   // Width of a rank number in a result.
   localparam int RANK_ID_BITS = 6;

   // Collective kinds as written to the kind register.
   typedef enum logic [2:0] {
      KIND_ALLREDUCE     = 3'd0,
      KIND_ALLGATHER     = 3'd1,
      KIND_REDUCESCATTER = 3'd2,
      KIND_BROADCAST     = 3'd3,
      KIND_ALLTOALL      = 3'd4
   } kind_type;

   // Operation carried by one step.
   typedef enum logic [1:0] {
      OP_SEND   = 2'd0,
      OP_REDUCE = 2'd1,
      OP_COPY   = 2'd2
   } op_type;

   // Register numbers on the control port (address bits [4:3]).
   typedef enum logic [1:0] {
      CSR_KIND  = 2'd0,
      CSR_RANKS = 2'd1,
      CSR_BYTES = 2'd2
   } csr_index_type;

   // Description of one step, without the byte placement.
   typedef struct packed {
      logic                    step_valid;
      op_type                  step_op;
      logic [RANK_ID_BITS-1:0] source_rank;
      logic [RANK_ID_BITS-1:0] dest_rank;
      logic                    last_in_stage;
      logic                    last_in_plan;
   } step_info_type;

   // Rank count as the plan uses it: zero counts as one, large values saturate.
   function automatic logic [RANK_CNT_BITS-1:0] eff_ranks(input logic [RANK_CNT_BITS-1:0] raw);
      logic [RANK_CNT_BITS-1:0] n;
      n = raw;
      if (raw == '0) begin
         n = RANK_CNT_BITS'(1);
      end else if (raw > RANK_CNT_BITS'(MAX_RANKS)) begin
         n = RANK_CNT_BITS'(MAX_RANKS);
      end
      return n;
   endfunction

endpackage

[rtl/csg_chunk_div.sv]
module csg_chunk_div #(
   parameter int BYTE_BITS = 48
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [BYTE_BITS-1:0]               dividend,
   input  logic [csg_pkg::RANK_CNT_BITS-1:0]  divisor,
   output logic                               busy,
   output logic [BYTE_BITS-1:0]               chunk
);
   import csg_pkg::*;

   localparam int CNT_W = $clog2(BYTE_BITS + 1);

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [BYTE_BITS-1:0]     quo_ff, quo_in;
   logic [RANK_CNT_BITS-1:0] rem_ff, rem_in;
   logic [RANK_CNT_BITS-1:0] div_ff, div_in;
   logic [BYTE_BITS-1:0]     chunk_ff, chunk_in;
   logic [RANK_CNT_BITS:0]   rem_sh;
   logic                     fits;

   // One restoring division step: bring in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[BYTE_BITS-1]};
      fits     = rem_sh >= {1'b0, div_ff};
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      chunk_in = chunk_ff;
      if (start) begin
         count_in = CNT_W'(BYTE_BITS);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - CNT_W'(1);
         quo_in   = {quo_ff[BYTE_BITS-2:0], fits};
         rem_in   = fits ? RANK_CNT_BITS'(rem_sh - {1'b0, div_ff})
                         : rem_sh[RANK_CNT_BITS-1:0];
         // The last step delivers the quotient, with a floor of one byte.
         if (count_ff == CNT_W'(1)) begin
            chunk_in = (quo_in == '0) ? BYTE_BITS'(1) : quo_in;
         end
      end
   end

   // Control state and the chunk size reset; the datapath needs none.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         chunk_ff <= BYTE_BITS'(1);
      end else begin
         count_ff <= count_in;
         chunk_ff <= chunk_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy  = count_ff != '0;
   assign chunk = chunk_ff;

endmodule

[rtl/csg_step_calc.sv]
module csg_step_calc #(
   parameter int BYTE_BITS = 48
) (
   input  logic [2:0]                         kind,
   input  logic [csg_pkg::RANK_CNT_BITS-1:0]  ranks,
   input  logic [6:0]                         stage,
   input  logic [6:0]                         step,
   input  logic [BYTE_BITS-1:0]               chunk,
   input  logic [BYTE_BITS-1:0]               total_bytes,
   output csg_pkg::step_info_type             info,
   output logic [BYTE_BITS-1:0]               byte_offset,
   output logic [BYTE_BITS-1:0]               byte_length
);
   import csg_pkg::*;

   logic [7:0]  n8, nm1, k8, s8;
   logic        ar_rs, with_reduce, red_row;
   logic [7:0]  round8, ring_stages, ring_steps, r8;
   logic [7:0]  snd_dst, snd_t, snd_idx, red_src, red_t, red_idx;
   logic [7:0]  bc_stages, dist8, bc_sum, bc_pairs, bc_steps;
   logic [3:0]  bc_sh;
   logic [12:0] bc_src_w, bc_dst_w;
   logic [7:0]  a_t, a_dst;
   logic [7:0]  stages, steps, src, dst, idx;
   op_type      op;
   logic [BYTE_BITS-1:0] len;
   logic [BYTE_BITS+5:0] prod;
   logic        valid, last_stage;

   assign n8  = {1'b0, ranks};
   assign nm1 = n8 - 8'd1;
   assign k8  = {1'b0, step};
   assign s8  = {1'b0, stage};

   // Ring schedules: all-reduce runs reduce-scatter stages, then all-gather stages.
   always_comb begin
      ar_rs       = s8 < nm1;
      round8      = (kind == KIND_ALLREDUCE && !ar_rs) ? s8 - nm1 : s8;
      with_reduce = (kind == KIND_ALLREDUCE && ar_rs) || kind == KIND_REDUCESCATTER;
      ring_stages = (kind == KIND_ALLREDUCE) ? {nm1[6:0], 1'b0} : nm1;
      ring_steps  = with_reduce ? {n8[6:0], 1'b0} : n8;
      red_row     = with_reduce && k8 >= n8;
      r8          = k8 - n8;
      // Send row: rank k to k+1 on chunk k-round, all modulo the rank count.
      snd_dst     = (k8 + 8'd1 == n8) ? 8'd0 : k8 + 8'd1;
      snd_t       = k8 + n8 - round8;
      snd_idx     = (snd_t >= n8) ? snd_t - n8 : snd_t;
      // Reduce row: rank r-1 into r on chunk r-round-1.
      red_src     = (r8 == 8'd0) ? nm1 : r8 - 8'd1;
      red_t       = r8 + n8 - round8 - 8'd1;
      red_idx     = (red_t >= n8) ? red_t - n8 : red_t;
   end

   // Binary-tree broadcast: stage s pairs rank i*2^(s+1) with i*2^(s+1)+2^s.
   always_comb begin
      bc_stages = 8'd0;
      for (int i = 0; i < 7; i++) begin
         if (n8 > (8'd1 << i)) begin
            bc_stages = 8'(i + 1);
         end
      end
      dist8    = 8'd1 << stage[2:0];
      bc_sum   = n8 + dist8 - 8'd1;
      bc_sh    = {1'b0, stage[2:0]} + 4'd1;
      bc_pairs = bc_sum >> bc_sh;
      bc_steps = {bc_pairs[6:0], 1'b0};
      bc_src_w = 13'(k8[7:1]) << bc_sh;
      bc_dst_w = bc_src_w + 13'(dist8);
   end

   // Pairwise all-to-all: stage s sends rank k's chunk to rank k+s.
   always_comb begin
      a_t   = k8 + s8;
      a_dst = (a_t >= n8) ? a_t - n8 : a_t;
   end

   // Select the schedule of the configured kind.
   always_comb begin
      stages = 8'd0;
      steps  = 8'd0;
      op     = OP_SEND;
      src    = 8'd0;
      dst    = 8'd0;
      idx    = 8'd0;
      len    = '0;
      case (kind) inside
         KIND_ALLREDUCE, KIND_ALLGATHER, KIND_REDUCESCATTER: begin
            stages = ring_stages;
            steps  = ring_steps;
            op     = red_row ? OP_REDUCE : OP_SEND;
            src    = red_row ? red_src : k8;
            dst    = red_row ? r8 : snd_dst;
            idx    = red_row ? red_idx : snd_idx;
            len    = chunk;
         end
         KIND_BROADCAST: begin
            stages = bc_stages;
            steps  = bc_steps;
            op     = k8[0] ? OP_COPY : OP_SEND;
            src    = bc_src_w[7:0];
            dst    = bc_dst_w[7:0];
            len    = total_bytes;
         end
         KIND_ALLTOALL: begin
            stages = n8;
            steps  = n8;
            op     = (s8 == 8'd0) ? OP_COPY : OP_SEND;
            src    = k8;
            dst    = a_dst;
            idx    = a_dst;
            len    = chunk;
         end
         default: begin
            stages = 8'd0;
         end
      endcase
   end

   // Chunk placement: index below 64 times the chunk size.
   assign prod = idx[5:0] * chunk;

   // Positions past the end of the plan answer with every field zero.
   always_comb begin
      valid              = s8 < stages && k8 < steps;
      last_stage         = valid && k8 == steps - 8'd1;
      info.step_valid    = valid;
      info.step_op       = valid ? op : OP_SEND;
      info.source_rank   = valid ? src[RANK_ID_BITS-1:0] : '0;
      info.dest_rank     = valid ? dst[RANK_ID_BITS-1:0] : '0;
      info.last_in_stage = last_stage;
      info.last_in_plan  = last_stage && s8 == stages - 8'd1;
      byte_offset        = valid ? prod[BYTE_BITS-1:0] : '0;
      byte_length        = valid ? len : '0;
   end

endmodule

[rtl/collective_step_generator.sv]
// A request accepted on req_* passes the request register, then the result register, to rsp_*.
// Throughput: one request per cycle; rsp_tready stalls back through the two pipeline registers.
// A write to rank_count or total_bytes recomputes the chunk size with a bit-serial divider
// (one quotient bit a cycle); req_tready is low meanwhile.
// Reset is synchronous and active high: kind 0, one rank, zero bytes, chunk size one byte.
module collective_step_generator #(
   parameter int BYTE_COUNT_BITS = 48
) (
   input  logic                                        clock,
   input  logic                                        reset,
   // Requests.
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [15:0]                                 req_tdata,  // stage_index, step_index
   // Results.
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // step_valid, source_rank, dest_rank, byte_offset, byte_length, last_in_stage
   output logic [((2*BYTE_COUNT_BITS+14+7)/8)*8-1:0]   rsp_tdata,
   output logic [1:0]                                  rsp_tuser,  // step_op
   output logic                                        rsp_tlast,  // last_in_plan
   // Control registers.
   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [4:0]                                  csr_paddr,
   input  logic [63:0]                                 csr_pwdata,
   output logic [63:0]                                 csr_prdata,
   output logic                                        csr_pready
);
   import csg_pkg::*;

   localparam int B         = BYTE_COUNT_BITS;
   localparam int RSP_BITS  = 2 * B + 14;
   localparam int RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   logic [2:0]               kind_ff, kind_in;
   logic [RANK_CNT_BITS-1:0] rank_ff, rank_in;
   logic [B-1:0]             bytes_ff, bytes_in;
   logic                     div_start_ff, div_start_in;
   logic                     csr_wr;
   csr_index_type            csr_idx;
   logic                     div_busy, cfg_busy;
   logic [B-1:0]             chunk;
   logic [RANK_CNT_BITS-1:0] ranks;

   logic                     s1_valid_ff, s1_valid_in;
   logic [6:0]               s1_stage_ff, s1_stage_in;
   logic [6:0]               s1_step_ff, s1_step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   step_info_type            info_ff, info_in;
   logic [B-1:0]             offset_ff, offset_in;
   logic [B-1:0]             length_ff, length_in;
   step_info_type            calc_info;
   logic [B-1:0]             calc_offset, calc_length;
   logic                     adv_rsp, adv_s1;

   // Register writes; a new rank count or size restarts the chunk division.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_index_type'(csr_paddr[4:3]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      kind_in      = kind_ff;
      rank_in      = rank_ff;
      bytes_in     = bytes_ff;
      div_start_in = 1'b0;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_KIND:  kind_in = csr_pwdata[2:0];
            CSR_RANKS: begin
               rank_in      = csr_pwdata[RANK_CNT_BITS-1:0];
               div_start_in = 1'b1;
            end
            CSR_BYTES: begin
               bytes_in     = csr_pwdata[B-1:0];
               div_start_in = 1'b1;
            end
            default: div_start_in = 1'b0;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      unique case (csr_idx)
         CSR_KIND:  csr_prdata = 64'(kind_ff);
         CSR_RANKS: csr_prdata = 64'(rank_ff);
         CSR_BYTES: csr_prdata = 64'(bytes_ff);
         default:   csr_prdata = '0;
      endcase
   end

   assign ranks = eff_ranks(rank_ff);

   csg_chunk_div #(
      .BYTE_BITS (B)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (bytes_ff),
      .divisor  (ranks),
      .busy     (div_busy),
      .chunk    (chunk)
   );

   assign cfg_busy = div_start_ff || div_busy;

   // Two-register pipeline: request register, then result register.
   assign adv_rsp    = !rsp_valid_ff || rsp_tready;
   assign adv_s1     = !s1_valid_ff || adv_rsp;
   assign req_tready = adv_s1 && !cfg_busy;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_stage_in  = s1_stage_ff;
      s1_step_in   = s1_step_ff;
      rsp_valid_in = rsp_valid_ff;
      info_in      = info_ff;
      offset_in    = offset_ff;
      length_in    = length_ff;
      if (adv_s1) begin
         s1_valid_in = req_tvalid && req_tready;
         s1_stage_in = req_tdata[6:0];
         s1_step_in  = req_tdata[13:7];
      end
      if (adv_rsp) begin
         rsp_valid_in = s1_valid_ff;
         info_in      = calc_info;
         offset_in    = calc_offset;
         length_in    = calc_length;
      end
   end

   csg_step_calc #(
      .BYTE_BITS (B)
   ) u_calc (
      .kind        (kind_ff),
      .ranks       (ranks),
      .stage       (s1_stage_ff),
      .step        (s1_step_ff),
      .chunk       (chunk),
      .total_bytes (bytes_ff),
      .info        (calc_info),
      .byte_offset (calc_offset),
      .byte_length (calc_length)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= KIND_ALLREDUCE;
         rank_ff      <= RANK_CNT_BITS'(1);
         bytes_ff     <= '0;
         div_start_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         rank_ff      <= rank_in;
         bytes_ff     <= bytes_in;
         div_start_ff <= div_start_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_stage_ff <= s1_stage_in;
      s1_step_ff  <= s1_step_in;
      info_ff     <= info_in;
      offset_ff   <= offset_in;
      length_ff   <= length_in;
   end

   // Result channel.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = info_ff.step_op;
   assign rsp_tlast  = info_ff.last_in_plan;
   assign rsp_tdata  = RSP_WIDTH'({info_ff.last_in_stage, length_ff, offset_ff,
                                   info_ff.dest_rank, info_ff.source_rank,
                                   info_ff.step_valid});

   // The chunk size never drops to zero.
   a_chunk_nonzero: assert property (@(posedge clock) disable iff (reset)
      chunk != '0)
      else $error("chunk size is zero");

   // A rank count or size write blocks requests until the chunk is derived.
   a_write_blocks: assert property (@(posedge clock) disable iff (reset)
      csr_wr && (csr_idx == CSR_RANKS || csr_idx == CSR_BYTES) |=> !req_tready)
      else $error("request taken while chunk size is being derived");

   // A request in the first register moves to the result register when it is free.
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (!rsp_valid_ff || rsp_tready) |=> rsp_valid_ff)
      else $error("request lost between pipeline registers");

   // A valid end-of-plan step is always the end of its stage too.
   a_plan_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && info_ff.last_in_plan |-> info_ff.last_in_stage && info_ff.step_valid)
      else $error("end of plan without end of stage");

endmodule

[tb/tb_collective_step_generator.sv]
`timescale 1ns / 100ps

import csg_pkg::*;

// One step of a plan, as the result port carries it.
typedef struct packed {
   logic                    valid;
   op_type                  op;
   logic [RANK_ID_BITS-1:0] src;
   logic [RANK_ID_BITS-1:0] dst;
   logic [47:0]             offset;
   logic [47:0]             length;
   logic                    stage_end;
   logic                    plan_end;
} sched_step_type;

// Keeps its own copy of the registers, works out the step that each request names
// and compares the results in order.
class schedule_scoreboard;
   logic [2:0]     kind;
   logic [6:0]     ranks_raw;
   logic [47:0]    message_bytes;
   logic [47:0]    piece_size;
   sched_step_type pending_steps[$];
   int unsigned    failures;

   function new();
      kind          = KIND_ALLREDUCE;
      ranks_raw     = 7'd1;
      message_bytes = '0;
      piece_size    = 48'd1;
      failures      = 0;
   endfunction

   // Zero ranks count as one; anything above the maximum saturates.
   function longint unsigned ranks();
      if (ranks_raw == 0) return 1;
      if (ranks_raw > MAX_RANKS) return MAX_RANKS;
      return ranks_raw;
   endfunction

   function void update_chunk();
      longint unsigned q;
      q = message_bytes / ranks();
      piece_size = (q == 0) ? 48'd1 : 48'(q);
   endfunction

   function void write_register(logic [1:0] idx, logic [63:0] value);
      case (idx)
         CSR_KIND: kind = value[2:0];
         CSR_RANKS: begin
            ranks_raw = value[6:0];
            update_chunk();
         end
         CSR_BYTES: begin
            message_bytes = value[47:0];
            update_chunk();
         end
         default: ;
      endcase
   endfunction

   function longint unsigned stage_count();
      longint unsigned n;
      n = ranks();
      case (kind)
         KIND_ALLREDUCE: return 2 * (n - 1);
         KIND_ALLGATHER, KIND_REDUCESCATTER: return n - 1;
         KIND_BROADCAST: return $clog2(n);
         KIND_ALLTOALL: return n;
         default: return 0;
      endcase
   endfunction

   // Only meaningful for a stage that exists.
   function longint unsigned steps_in_stage(longint unsigned stage);
      longint unsigned n;
      longint unsigned pair_gap;
      n = ranks();
      case (kind)
         KIND_ALLREDUCE: return (stage < n - 1) ? 2 * n : n;
         KIND_REDUCESCATTER: return 2 * n;
         KIND_BROADCAST: begin
            pair_gap = 64'd1 << stage;
            return 2 * ((n - pair_gap + 2 * pair_gap - 1) / (2 * pair_gap));
         end
         default: return n;
      endcase
   endfunction

   // Ring stage: sends from every rank to its successor, then, for reducing
   // stages, one reduce per rank from its predecessor.
   function void ring_step(longint unsigned n, longint unsigned round, longint unsigned k,
                           bit with_reduce, output op_type op, output longint unsigned src,
                           output longint unsigned dst, output longint unsigned off);
      longint unsigned r;
      if (!with_reduce || k < n) begin
         op  = OP_SEND;
         src = k;
         dst = (k + 1) % n;
         off = ((k + n - round) % n) * piece_size;
      end else begin
         r   = k - n;
         op  = OP_REDUCE;
         src = (r + n - 1) % n;
         dst = r;
         off = ((r + 2 * n - round - 1) % n) * piece_size;
      end
   endfunction

   function sched_step_type plan_step_at(longint unsigned stage, longint unsigned step);
      sched_step_type  s;
      longint unsigned n, stages, steps, pair_gap, src, dst, off, len;
      op_type          op;
      s      = '0;
      n      = ranks();
      stages = stage_count();
      op     = OP_SEND;
      src    = 0;
      dst    = 0;
      off    = 0;
      len    = piece_size;
      if (stage >= stages) return s;
      steps = steps_in_stage(stage);
      if (step >= steps) return s;
      case (kind)
         KIND_ALLREDUCE: begin
            if (stage < n - 1) begin
               ring_step(n, stage, step, 1'b1, op, src, dst, off);
            end else begin
               ring_step(n, stage - (n - 1), step, 1'b0, op, src, dst, off);
            end
         end
         KIND_ALLGATHER: ring_step(n, stage, step, 1'b0, op, src, dst, off);
         KIND_REDUCESCATTER: ring_step(n, stage, step, 1'b1, op, src, dst, off);
         KIND_BROADCAST: begin
            // Tree pairs: each pair is a send followed by a copy of the whole message.
            pair_gap = 64'd1 << stage;
            src      = (step >> 1) * 2 * pair_gap;
            dst      = src + pair_gap;
            op       = ((step & 1) != 0) ? OP_COPY : OP_SEND;
            len      = message_bytes;
         end
         default: begin
            src = step;
            dst = (step + stage) % n;
            op  = (stage == 0) ? OP_COPY : OP_SEND;
            off = dst * piece_size;
         end
      endcase
      s.valid     = 1'b1;
      s.op        = op;
      s.src       = RANK_ID_BITS'(src);
      s.dst       = RANK_ID_BITS'(dst);
      s.offset    = 48'(off);
      s.length    = 48'(len);
      s.stage_end = (step == steps - 1);
      s.plan_end  = s.stage_end && (stage == stages - 1);
      return s;
   endfunction

   function void note_request(logic [6:0] stage, logic [6:0] step);
      pending_steps.insert(pending_steps.size(), plan_step_at(stage, step));
   endfunction

   function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function void check_result(logic [111:0] data, logic [1:0] user, logic last);
      sched_step_type want;
      if (pending_steps.size() == 0) begin
         $error("result arrived with no request outstanding");
         failures++;
         return;
      end
      want = pending_steps.pop_front();
      compare_field("step_valid", want.valid, data[0]);
      compare_field("step_op", want.op, user);
      compare_field("source_rank", want.src, data[6:1]);
      compare_field("dest_rank", want.dst, data[12:7]);
      compare_field("byte_offset", want.offset, data[60:13]);
      compare_field("byte_length", want.length, data[108:61]);
      compare_field("last_in_stage", want.stage_end, data[109]);
      compare_field("last_in_plan", want.plan_end, last);
   endfunction
endclass

module tb_collective_step_generator;

   localparam int          CYCLE_LIMIT   = 400000;
   localparam int          PHASES        = 32;
   localparam int          PHASE_ITEMS   = 54;
   localparam int          HOLD_AFTER    = 700;
   localparam int          HOLD_CYCLES   = 300;
   localparam int          IDLE_PERCENT  = 26;
   localparam logic [1:0]  UNUSED_REG    = 2'd3;
   localparam logic [2:0]  KIND_RESERVED = 3'd6;
   localparam logic [47:0] BYTES_MAX     = 48'hFFFF_FFFF_FFFF;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [15:0]  req_tdata;    // stage_index, step_index
   logic         rsp_tvalid;
   logic         rsp_tready;
   // step_valid, source_rank, dest_rank, byte_offset, byte_length, last_in_stage
   logic [111:0] rsp_tdata;
   logic [1:0]   rsp_tuser;    // step_op
   logic         rsp_tlast;    // last_in_plan
   logic         csr_psel;
   logic         csr_penable;
   logic         csr_pwrite;
   logic [4:0]   csr_paddr;
   logic [63:0]  csr_pwdata;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   schedule_scoreboard board = new();
   bit          calm;
   int unsigned cycle_count;
   int unsigned results_seen;
   int unsigned hold_left;
   bit          hold_done;

   collective_step_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("collective_step_generator regression: fail");
         $finish;
      end
   end

   // Result side: check every accepted result and throttle rsp_tready, with one long
   // hold-off once enough results have been seen.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
            results_seen++;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Offer one request and wait until it is taken; tvalid stays high afterwards.
   task automatic send_request(input logic [6:0] stage, input logic [6:0] step);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, step, stage};
      do @(posedge clock); while (!req_tready);
      board.note_request(stage, step);
   endtask

   // Stop offering and wait until every outstanding result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_steps.size() != 0);
   endtask

   // Setup and access cycle; psel is left high so writes can follow back to back.
   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_register(idx, value);
   endtask

   // Reprogram all registers once the block is idle; upper bits carry random junk.
   task automatic apply_settings(input logic [2:0] kind, input logic [6:0] ranks,
                                 input logic [63:0] bytes, input bit poke_unused);
      logic [63:0] kind_word;
      logic [63:0] ranks_word;
      drain_results();
      kind_word        = {$urandom, $urandom};
      kind_word[2:0]   = kind;
      ranks_word       = {$urandom, $urandom};
      ranks_word[6:0]  = ranks;
      write_register(CSR_KIND, kind_word);
      write_register(CSR_RANKS, ranks_word);
      write_register(CSR_BYTES, bytes);
      if (poke_unused) write_register(UNUSED_REG, {$urandom, $urandom});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly queries inside the plan or just past its edges, the rest random.
   task automatic send_random_request();
      longint unsigned stages;
      longint unsigned steps;
      logic [6:0]      stage;
      logic [6:0]      step;
      stages = board.stage_count();
      stage  = 7'($urandom_range(126));
      step   = 7'($urandom_range(127));
      if (stages != 0 && $urandom_range(99) < 80) begin
         stage = 7'($urandom_range(stages));
         if (stage < stages) begin
            steps = board.steps_in_stage(stage);
            step  = 7'($urandom_range(steps));
         end
      end
      send_request(stage, step);
   endtask

   initial begin
      logic [2:0]  kind;
      logic [6:0]  ranks;
      logic [63:0] bytes;
      reset       = 1'b1;
      calm        = 1'b0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset plan: one rank all-reduce has no stages at all.
      send_request(7'd0, 7'd0);
      send_request(7'd126, 7'd127);

      // Four-rank all-reduce: first send, last reduce, past the end, end of plan.
      apply_settings(KIND_ALLREDUCE, 7'd4, 64'd1000, 1'b0);
      send_request(7'd0, 7'd0);
      send_request(7'd0, 7'd7);
      send_request(7'd0, 7'd8);
      send_request(7'd5, 7'd3);
      send_request(7'd6, 7'd0);

      // Largest rank count for the plain ring kinds, and the largest message for reduce-scatter.
      apply_settings(KIND_REDUCESCATTER, 7'd64, {16'hFFFF, BYTES_MAX}, 1'b0);
      send_request(7'd62, 7'd127);
      send_request(7'd0, 7'd64);
      apply_settings(KIND_ALLGATHER, 7'd64, 64'd63, 1'b0);
      send_request(7'd62, 7'd63);

      // Broadcast over an uneven tree.
      apply_settings(KIND_BROADCAST, 7'd5, 64'd12345, 1'b0);
      send_request(7'd0, 7'd0);
      send_request(7'd0, 7'd1);
      send_request(7'd1, 7'd3);
      send_request(7'd2, 7'd1);
      send_request(7'd3, 7'd0);

      // All-to-all with one rank, zero ranks and a saturated rank count.
      apply_settings(KIND_ALLTOALL, 7'd1, 64'd0, 1'b0);
      send_request(7'd0, 7'd0);
      send_request(7'd0, 7'd1);
      apply_settings(KIND_ALLTOALL, 7'd0, 64'd77, 1'b0);
      send_request(7'd0, 7'd0);
      apply_settings(KIND_ALLTOALL, 7'd127, 64'd6400, 1'b0);
      send_request(7'd63, 7'd63);

      // Undefined kind answers with an all-zero step; a write to an unused register changes nothing.
      apply_settings(KIND_RESERVED, 7'd8, 64'd800, 1'b1);
      send_request(7'd0, 7'd0);
      apply_settings(KIND_BROADCAST, 7'd1, 64'd5, 1'b1);
      send_request(7'd0, 7'd0);

      // Random phases, each with its own settings.
      for (int phase = 0; phase < PHASES; phase++) begin
         kind = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
         case ($urandom_range(9))
            0: ranks = 7'd0;
            1: ranks = 7'd1;
            2: ranks = 7'd2;
            3: ranks = 7'd64;
            4: ranks = 7'($urandom_range(127, 65));
            5: ranks = 7'($urandom_range(64, 17));
            default: ranks = 7'($urandom_range(16, 2));
         endcase
         case ($urandom_range(5))
            0: bytes = 64'd0;
            1: bytes = {16'h0000, BYTES_MAX};
            2: bytes = 64'($urandom_range(200));
            default: bytes = {$urandom, $urandom};
         endcase
         apply_settings(kind, ranks, bytes, $urandom_range(3) == 0);
         calm = (phase >= 12 && phase < 16);
         repeat (PHASE_ITEMS) send_random_request();
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (board.failures == 0 && board.pending_steps.size() == 0) begin
         $display("collective_step_generator regression: pass");
      end else begin
         $display("collective_step_generator regression: fail");
      end
      $finish;
   end

endmodule
